/* hdl/cbpe_pkg.sv */
`default_nettype none
// Package for the cubic Bezier point evaluator.
// Holds coordinate and field widths, register indexes and register reset values.
// Depends on nothing; every other file of the block imports it.
package cbpe_pkg;

   localparam int STEPS_DEFAULT = 20;
   localparam int COORD_W       = 12;
   localparam int STEP_W        = 5;
   localparam int CSR_IDX_W     = 3;
   localparam int NUM_REGS      = 8;

   typedef logic [COORD_W-1:0]   coord_type;
   typedef logic [STEP_W-1:0]    step_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_P0_X = 3'd0;
   localparam csr_idx_type REG_P0_Y = 3'd1;
   localparam csr_idx_type REG_P1_X = 3'd2;
   localparam csr_idx_type REG_P1_Y = 3'd3;
   localparam csr_idx_type REG_P2_X = 3'd4;
   localparam csr_idx_type REG_P2_Y = 3'd5;
   localparam csr_idx_type REG_P3_X = 3'd6;
   localparam csr_idx_type REG_P3_Y = 3'd7;

   localparam coord_type REG_RESET [NUM_REGS] = '{
      12'd100, 12'd100, 12'd200, 12'd300, 12'd400, 12'd300, 12'd300, 12'd100
   };

endpackage
`default_nettype wire

/* hdl/cbpe_req_if.sv */
`default_nettype none
// Request channel of the cubic Bezier point evaluator: valid, ready and the step index.
// Depends on cbpe_pkg for the field width.
interface cbpe_req_if
   import cbpe_pkg::*;
   ;
   logic     valid;
   logic     ready;
   step_type step_index;

   modport source (output valid, output step_index, input ready);
   modport sink (input valid, input step_index, output ready);
endinterface
`default_nettype wire

/* hdl/cbpe_rsp_if.sv */
`default_nettype none
// Response channel of the cubic Bezier point evaluator: valid, ready and the curve point.
// Depends on cbpe_pkg for the coordinate type.
interface cbpe_rsp_if
   import cbpe_pkg::*;
   ;
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink (input valid, input point_x, input point_y, output ready);
endinterface
`default_nettype wire

/* hdl/cbpe_axis.sv */
`default_nettype none
// One coordinate of the evaluator: weighted sum of four control coordinates and the
// division by STEPS cubed through a reciprocal multiply with one correction step.
// Depends on cbpe_pkg; five register stages, all advanced by one enable.
module cbpe_axis
   import cbpe_pkg::*;
#(
   parameter int STEPS = STEPS_DEFAULT,
   localparam int DEN = STEPS * STEPS * STEPS,
   localparam int WW  = $clog2(DEN + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [3:0][WW-1:0]    weight,
   input  wire logic [3:0][COORD_W-1:0] coord,
   output logic [COORD_W-1:0]         point
);

   localparam int NW = WW + COORD_W;
   localparam int RW = COORD_W + 2;
   localparam longint unsigned RECIP_L = (64'd1 << NW) / 64'(DEN);
   localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
   localparam logic [NW-1:0] DEN_N = NW'(DEN);

   logic [3:0][NW-1:0]    prod_ff, prod_in;
   logic [NW-1:0]         sum_ff, sum_in;
   logic [NW+1:0]         sum_full;
   logic [NW-1:0]         num5_ff;
   logic [NW+RW-1:0]      rp_ff, rp_in;
   logic [NW-1:0]         num6_ff;
   logic [COORD_W-1:0]    q06_ff, q06_in;
   logic [NW-1:0]         qd6_ff, qd6_in;
   logic [NW-1:0]         rem;
   logic [COORD_W:0]      q_full;
   logic [COORD_W-1:0]    point_ff, point_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = NW'(weight[k]) * NW'(coord[k]);
      end
      sum_full = (NW+2)'(prod_ff[0]) + (NW+2)'(prod_ff[1])
               + (NW+2)'(prod_ff[2]) + (NW+2)'(prod_ff[3]);
      sum_in = sum_full[NW-1:0];
      rp_in = (NW+RW)'(sum_ff) * (NW+RW)'(RECIP);
      q06_in = rp_ff[NW +: COORD_W];
      qd6_in = NW'(q06_in) * DEN_N;
      rem = num6_ff - qd6_ff;
      q_full = (COORD_W+1)'(q06_ff) + (COORD_W+1)'(rem >= DEN_N);
      point_in = q_full[COORD_W] ? {COORD_W{1'b1}} : q_full[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         sum_ff   <= sum_in;
         num5_ff  <= sum_ff;
         rp_ff    <= rp_in;
         num6_ff  <= num5_ff;
         q06_ff   <= q06_in;
         qd6_ff   <= qd6_in;
         point_ff <= point_in;
      end
   end

   assign point = point_ff;

endmodule
`default_nettype wire

/* hdl/cubic_bezier_point_evaluator.sv */
`default_nettype none
// Top level of the cubic Bezier point evaluator: control point registers, the
// Bernstein weight stages and two coordinate datapaths. Depends on cbpe_pkg,
// cbpe_req_if, cbpe_rsp_if and cbpe_axis.
//
//   Channel   Direction  Carries
//   req_chan  in         step_index (t = step_index / STEPS, saturated at STEPS)
//   rsp_chan  out        point_x, point_y
//   csr_*     in         control point writes, indexes 0..7
//
// There are seven register stages between an accepted item and its result on rsp_chan.
// One item is accepted per cycle unless the output stalls; every stage takes a new one.
// All stages advance together whenever the output register is empty or taken,
// so a stalled output holds the whole pipeline and req_chan.ready drops.
// Reset is synchronous, clears the stage valid bits and reloads the control points.
module cubic_bezier_point_evaluator
   import cbpe_pkg::*;
#(
   parameter int STEPS = STEPS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   cbpe_req_if.sink         req_chan,
   cbpe_rsp_if.source       rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire csr_idx_type csr_index,
   input  wire coord_type   csr_wr_data
);

   localparam int DEN    = STEPS * STEPS * STEPS;
   localparam int WW     = $clog2(DEN + 1);
   localparam int SW     = $clog2(STEPS + 1);
   localparam int NSTAGE = 7;

   coord_type ctrl_ff [NUM_REGS];
   logic [NSTAGE-1:0] vld_ff, vld_in;
   logic adv;

   logic [SW-1:0]   i_sat;
   logic [SW-1:0]   i1_ff, i1_in, j1_ff, j1_in;
   logic [2*SW-1:0] ii1_ff, ii1_in, jj1_ff, jj1_in;
   logic [SW+1:0]   tri_i, tri_j;
   logic [3*SW-1:0] w0_full, w3_full;
   logic [3*SW+1:0] w1_full, w2_full;
   logic [3:0][WW-1:0] w2_ff, w2_in;
   logic [3:0][COORD_W-1:0] coord_x, coord_y;

   // Control point registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            ctrl_ff[k] <= REG_RESET[k];
         end
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_P0_X: ctrl_ff[REG_P0_X] <= csr_wr_data;
            REG_P0_Y: ctrl_ff[REG_P0_Y] <= csr_wr_data;
            REG_P1_X: ctrl_ff[REG_P1_X] <= csr_wr_data;
            REG_P1_Y: ctrl_ff[REG_P1_Y] <= csr_wr_data;
            REG_P2_X: ctrl_ff[REG_P2_X] <= csr_wr_data;
            REG_P2_Y: ctrl_ff[REG_P2_Y] <= csr_wr_data;
            REG_P3_X: ctrl_ff[REG_P3_X] <= csr_wr_data;
            REG_P3_Y: ctrl_ff[REG_P3_Y] <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign adv = !vld_ff[NSTAGE-1] || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_comb begin
      vld_in = {vld_ff[NSTAGE-2:0], req_chan.valid};
      if (32'(req_chan.step_index) > 32'(STEPS)) begin
         i_sat = SW'(STEPS);
      end else begin
         i_sat = SW'(req_chan.step_index);
      end
      i1_in  = i_sat;
      j1_in  = SW'(STEPS) - i_sat;
      ii1_in = (2*SW)'(i1_in) * (2*SW)'(i1_in);
      jj1_in = (2*SW)'(j1_in) * (2*SW)'(j1_in);
      tri_i  = (SW+2)'({i1_ff, 1'b0}) + (SW+2)'(i1_ff);
      tri_j  = (SW+2)'({j1_ff, 1'b0}) + (SW+2)'(j1_ff);
      w0_full = (3*SW)'(jj1_ff) * (3*SW)'(j1_ff);
      w1_full = (3*SW+2)'(tri_i) * (3*SW+2)'(jj1_ff);
      w2_full = (3*SW+2)'(tri_j) * (3*SW+2)'(ii1_ff);
      w3_full = (3*SW)'(ii1_ff) * (3*SW)'(i1_ff);
      w2_in[0] = WW'(w0_full);
      w2_in[1] = WW'(w1_full);
      w2_in[2] = WW'(w2_full);
      w2_in[3] = WW'(w3_full);
      coord_x = {ctrl_ff[REG_P3_X], ctrl_ff[REG_P2_X], ctrl_ff[REG_P1_X], ctrl_ff[REG_P0_X]};
      coord_y = {ctrl_ff[REG_P3_Y], ctrl_ff[REG_P2_Y], ctrl_ff[REG_P1_Y], ctrl_ff[REG_P0_Y]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i1_ff  <= i1_in;
         j1_ff  <= j1_in;
         ii1_ff <= ii1_in;
         jj1_ff <= jj1_in;
         w2_ff  <= w2_in;
      end
   end

   cbpe_axis #(.STEPS(STEPS)) u_axis_x (
      .clock  (clock),
      .en     (adv),
      .weight (w2_ff),
      .coord  (coord_x),
      .point  (rsp_chan.point_x)
   );

   cbpe_axis #(.STEPS(STEPS)) u_axis_y (
      .clock  (clock),
      .en     (adv),
      .weight (w2_ff),
      .coord  (coord_y),
      .point  (rsp_chan.point_y)
   );

   assign rsp_chan.valid = vld_ff[NSTAGE-1];

   // The pipeline comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> vld_ff == '0)
      else $error("pipeline not empty after reset");

   // A held pipeline keeps every item where it is.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

   // An accepted item always lands in the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && adv |=> vld_ff[0])
      else $error("accepted item lost at the first stage");

   // A result appears only through a pipeline advance from the stage before it.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(adv) && $past(vld_ff[NSTAGE-2]))
      else $error("result appeared without an item behind it");

endmodule
`default_nettype wire

/* tb/cubic_bezier_point_evaluator_tb.sv */
`timescale 1ns / 100ps
// Testbench for the cubic Bezier point evaluator: random and directed step indexes
// under several control point settings, checked against an integer curve predictor.
// Depends on cbpe_pkg, cbpe_req_if, cbpe_rsp_if and cubic_bezier_point_evaluator.
module cubic_bezier_point_evaluator_tb;
   import cbpe_pkg::*;

   localparam int STEPS        = STEPS_DEFAULT;
   localparam int PIPE_LATENCY = 7;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int LONG_HOLD    = 300;

   localparam int BASIS [4][4] = '{
      '{-1,  3, -3, 1},
      '{ 3, -6,  3, 0},
      '{-3,  3,  0, 0},
      '{ 1,  0,  0, 0}
   };

   typedef struct {
      step_type  step;
      coord_type x;
      coord_type y;
   } curve_point_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   csr_idx_type csr_index;
   coord_type   csr_wr_data;

   cbpe_req_if req_chan ();
   cbpe_rsp_if rsp_chan ();

   cubic_bezier_point_evaluator #(.STEPS(STEPS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   int              control_coord [NUM_REGS];
   step_type        step_queue [$];
   curve_point_type expected_points [$];
   int              queued_count   = 0;
   int              accepted_count = 0;
   int              error_count    = 0;
   int              cycle_count    = 0;
   logic            req_taken      = 1'b0;
   bit              sender_idle_on   = 1'b0;
   bit              receiver_idle_on = 1'b0;
   int              hold_requests  = 0;
   int              holds_granted  = 0;
   int              send_gap       = 0;
   int              stall_left     = 0;
   int              hold_left      = 0;

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic step_type draw_step();
      if ($urandom_range(0, 9) == 0) return step_type'($urandom_range(STEPS + 1, 31));
      return step_type'($urandom_range(0, STEPS));
   endfunction

   function automatic coord_type draw_coord();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return coord_type'($urandom_range(0, 4095));
   endfunction

   function automatic curve_point_type bezier_point(step_type step);
      curve_point_type pt;
      longint          coef [4];
      longint          i;
      longint          s;
      longint          num;
      longint          q;
      pt.step = step;
      s = STEPS;
      i = (int'(step) > STEPS) ? STEPS : int'(step);
      for (int axis = 0; axis < 2; axis++) begin
         for (int m = 0; m < 4; m++) begin
            coef[m] = 0;
            for (int j = 0; j < 4; j++) begin
               coef[m] += longint'(BASIS[m][j]) * longint'(control_coord[2 * j + axis]);
            end
         end
         num = i * i * i * coef[0] + i * i * s * coef[1] + i * s * s * coef[2]
             + s * s * s * coef[3];
         if (num < 0) num = 0;
         q = num / (s * s * s);
         if (q > 4095) q = 4095;
         if (axis == 0) pt.x = q[COORD_W-1:0];
         else pt.y = q[COORD_W-1:0];
      end
      return pt;
   endfunction

   task automatic write_register(csr_idx_type idx, coord_type value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      control_coord[idx] = int'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_curve(coord_type p0x, coord_type p0y, coord_type p1x, coord_type p1y,
                             coord_type p2x, coord_type p2y, coord_type p3x, coord_type p3y);
      write_register(REG_P0_X, p0x);
      write_register(REG_P0_Y, p0y);
      write_register(REG_P1_X, p1x);
      write_register(REG_P1_Y, p1y);
      write_register(REG_P2_X, p2x);
      write_register(REG_P2_Y, p2y);
      write_register(REG_P3_X, p3x);
      write_register(REG_P3_Y, p3y);
   endtask

   task automatic queue_step(step_type step);
      step_queue.push_back(step);
      queued_count++;
   endtask

   task automatic queue_random_steps(int count);
      for (int n = 0; n < count; n++) begin
         queue_step(draw_step());
      end
   endtask

   task automatic wait_for_drain();
      while (accepted_count != queued_count || expected_points.size() != 0) begin
         @(negedge clock);
      end
      repeat (PIPE_LATENCY + 2) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (send_gap > 0) begin
            req_chan.valid <= 1'b0;
            send_gap--;
         end else if (step_queue.size() != 0) begin
            req_chan.valid      <= 1'b1;
            req_chan.step_index <= step_queue.pop_front();
            send_gap = sender_idle_on ? draw_gap() : 0;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else if (holds_granted < hold_requests) begin
         rsp_chan.ready <= 1'b0;
         holds_granted++;
         hold_left = LONG_HOLD;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if (receiver_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = draw_gap();
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      curve_point_type want;
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            expected_points.push_back(bezier_point(req_chan.step_index));
            accepted_count++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_points.size() == 0) begin
               error_count++;
               $display("%0t: point (%0d,%0d) arrived with no item outstanding",
                        $time, rsp_chan.point_x, rsp_chan.point_y);
            end else begin
               want = expected_points.pop_front();
               if (rsp_chan.point_x !== want.x) begin
                  error_count++;
                  $display("%0t: point_x for step %0d: expected %0d, actual %0d",
                           $time, want.step, want.x, rsp_chan.point_x);
               end
               if (rsp_chan.point_y !== want.y) begin
                  error_count++;
                  $display("%0t: point_y for step %0d: expected %0d, actual %0d",
                           $time, want.step, want.y, rsp_chan.point_y);
               end
            end
         end
      end
   end

   initial begin
      step_type directed_steps [13] = '{0, 1, 2, 5, 10, 15, 19, 20, 21, 22, 31, 16, 8};
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = REG_P0_X;
      csr_wr_data         = '0;
      req_chan.valid      = 1'b0;
      req_chan.step_index = '0;
      rsp_chan.ready      = 1'b0;
      foreach (control_coord[k]) control_coord[k] = int'(REG_RESET[k]);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The reset curve first, then the corner settings of the control points.
      foreach (directed_steps[k]) queue_step(directed_steps[k]);
      wait_for_drain();
      load_curve('0, '0, '0, '0, '0, '0, '0, '0);
      queue_random_steps(20);
      wait_for_drain();
      load_curve('1, '1, '1, '1, '1, '1, '1, '1);
      queue_random_steps(20);
      wait_for_drain();
      load_curve('0, '1, '1, '0, '0, '1, '1, '0);
      queue_random_steps(20);
      wait_for_drain();
      load_curve('1, '0, '0, '1, '1, '0, '0, '1);
      queue_random_steps(20);
      wait_for_drain();

      for (int phase = 0; phase < 8; phase++) begin
         load_curve(draw_coord(), draw_coord(), draw_coord(), draw_coord(),
                    draw_coord(), draw_coord(), draw_coord(), draw_coord());
         if (phase == 2) begin
            // The output is held off while the input keeps offering items.
            sender_idle_on   = 1'b0;
            receiver_idle_on = 1'b0;
            hold_requests++;
            queue_random_steps(80);
            wait_for_drain();
         end
         sender_idle_on   = ($urandom_range(0, 3) != 0);
         receiver_idle_on = ($urandom_range(0, 3) != 0);
         queue_random_steps(130);
         wait_for_drain();
      end

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* cubic_bezier_point_evaluator.f */
hdl/cbpe_pkg.sv
hdl/cbpe_req_if.sv
hdl/cbpe_rsp_if.sv
hdl/cbpe_axis.sv
hdl/cubic_bezier_point_evaluator.sv
tb/cubic_bezier_point_evaluator_tb.sv
